### rtl/pretrade_risk_checker_core_assert.svh
// assertion macros for the risk checker rtl
// depends on nothing; included by modules that check their own logic
`ifndef PRETRADE_RISK_CHECKER_CORE_ASSERT_SVH
`define PRETRADE_RISK_CHECKER_CORE_ASSERT_SVH

// same-cycle implication
`define PRC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("risk checker assertion failed");

// next-cycle implication
`define PRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("risk checker assertion failed");

`endif

### rtl/prc_pkg.sv
// shared types and constants of the pre-trade risk checker
// depends on nothing
`default_nettype none

package prc_pkg;

  localparam logic [2:0] CMD_CHECK      = 3'd0;
  localparam logic [2:0] CMD_FILL       = 3'd1;
  localparam logic [2:0] CMD_KILL_ONE   = 3'd2;
  localparam logic [2:0] CMD_UNKILL_ONE = 3'd3;
  localparam logic [2:0] CMD_HALT_ALL   = 3'd4;
  localparam logic [2:0] CMD_RESUME_ALL = 3'd5;

  localparam logic [2:0] VERDICT_ACCEPT    = 3'd0;
  localparam logic [2:0] VERDICT_KILL      = 3'd1;
  localparam logic [2:0] VERDICT_BAD_PRICE = 3'd2;
  localparam logic [2:0] VERDICT_BAD_QTY   = 3'd3;
  localparam logic [2:0] VERDICT_POSITION  = 3'd4;
  localparam logic [2:0] VERDICT_RATE      = 3'd5;

  localparam logic [1:0] CFG_MAX_SYMBOL = 2'd0;
  localparam logic [1:0] CFG_MAX_NET    = 2'd1;
  localparam logic [1:0] CFG_WINDOW_MS  = 2'd2;
  localparam logic [1:0] CFG_MAX_ORDERS = 2'd3;

  localparam logic [30:0] RST_MAX_SYMBOL = 31'd1000;
  localparam logic [30:0] RST_MAX_NET    = 31'd10000;
  localparam logic [31:0] RST_WINDOW_MS  = 32'd1000;
  localparam logic [4:0]  RST_MAX_ORDERS = 5'd16;

  localparam logic [19:0] NS_PER_MS = 20'd1000000;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [3:0]         trader;
    logic [3:0]         symbol;
    logic signed [32:0] delta;
    logic [2:0]         pre_verdict;
    logic [63:0]        now;
  } job_t;

endpackage

`default_nettype wire

### rtl/prc_if.sv
// request, result and configuration channels of the risk checker
// depends on nothing
`default_nettype none

interface prc_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [3:0]         trader_index;
  logic [3:0]         symbol_index;
  logic               side;
  logic signed [31:0] quantity;
  logic signed [31:0] limit_price;
  logic               is_limit;
  logic [63:0]        timestamp_ns;

  modport source (output valid, command, trader_index, symbol_index, side, quantity,
                  limit_price, is_limit, timestamp_ns, input ready);
  modport sink (input valid, command, trader_index, symbol_index, side, quantity,
                limit_price, is_limit, timestamp_ns, output ready);
endinterface

interface prc_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         verdict;
  logic signed [31:0] symbol_position;
  logic signed [31:0] net_total;
  logic               trader_killed;
  logic [31:0]        orders_checked;
  logic [31:0]        orders_rejected;

  modport source (output valid, verdict, symbol_position, net_total, trader_killed,
                  orders_checked, orders_rejected, input ready);
  modport sink (input valid, verdict, symbol_position, net_total, trader_killed,
                orders_checked, orders_rejected, output ready);
endinterface

interface prc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/pretrade_risk_checker_core.sv
// path: a request passes the job queue, then the sequencer states idle and read, the
//   rate state for an order that reaches the rate ring (repeated per expired entry) and
//   result, then the result register; one request at a time, held in result on a stall
// reset: synchronous; position, net and ring head/count tables are cleared one entry a
//   cycle, with in_ch.ready low
// depends on prc_pkg, prc_if, prc_front, prc_queue, prc_back
`default_nettype none

module pretrade_risk_checker_core #(
  parameter int NUM_TRADERS = 16,
  parameter int NUM_SYMBOLS = 16,
  parameter int RATE_DEPTH  = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  prc_req_if.sink   in_ch,
  prc_res_if.source out_ch,
  prc_cfg_if.sink   cfg_ch
);

  logic          init_done;
  logic          q_full, q_empty, q_push, q_pop;
  prc_pkg::job_t push_job, head_job;

  prc_front u_front (
    .in_ch     (in_ch),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  prc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  prc_back #(
    .NUM_TRADERS (NUM_TRADERS),
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .RATE_DEPTH  (RATE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ch    (cfg_ch),
    .q_empty   (q_empty),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .init_done (init_done),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

### rtl/prc_front.sv
// front end: accepts requests and classifies them into queue jobs
// depends on prc_pkg and prc_req_if
`default_nettype none

module prc_front (
  prc_req_if.sink          in_ch,
  input  wire logic        init_done,
  input  wire logic        q_full,
  output logic             q_push,
  output prc_pkg::job_t    q_job
);

  logic signed [32:0] qty_x;

  assign in_ch.ready = init_done && !q_full;
  assign q_push      = in_ch.valid && in_ch.ready;
  assign qty_x       = 33'(in_ch.quantity);

  always_comb begin
    q_job.cmd    = in_ch.command;
    q_job.trader = in_ch.trader_index;
    q_job.symbol = in_ch.symbol_index;
    q_job.now    = in_ch.timestamp_ns;
    q_job.delta  = in_ch.side ? -qty_x : qty_x;
    priority if (in_ch.is_limit && in_ch.limit_price <= 32'sd0) begin
      q_job.pre_verdict = prc_pkg::VERDICT_BAD_PRICE;
    end else if (in_ch.quantity <= 32'sd0) begin
      q_job.pre_verdict = prc_pkg::VERDICT_BAD_QTY;
    end else begin
      q_job.pre_verdict = prc_pkg::VERDICT_ACCEPT;
    end
  end

endmodule

`default_nettype wire

### rtl/prc_queue.sv
// short job queue between front end and back end
// depends on prc_pkg
`default_nettype none

module prc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire prc_pkg::job_t push_job,
  input  wire logic          pop,
  output prc_pkg::job_t      head_job,
  output logic               empty,
  output logic               full
);

  localparam int AW = (prc_pkg::QUEUE_DEPTH > 1) ? $clog2(prc_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(prc_pkg::QUEUE_DEPTH + 1);

  prc_pkg::job_t   slot_r [prc_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (32'(cnt_r) == prc_pkg::QUEUE_DEPTH);
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == prc_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == prc_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

### rtl/prc_back.sv
// back end: position tables, kill flags, rate rings, counters and result register
// depends on prc_pkg, prc_cfg_if, prc_res_if and the assertion macro header
`default_nettype none
`include "pretrade_risk_checker_core_assert.svh"

module prc_back #(
  parameter int NUM_TRADERS = 16,
  parameter int NUM_SYMBOLS = 16,
  parameter int RATE_DEPTH  = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  prc_cfg_if.sink            cfg_ch,
  input  wire logic          q_empty,
  input  wire prc_pkg::job_t q_job,
  output logic               q_pop,
  output logic               init_done,
  prc_res_if.source          out_ch
);

  localparam int TW  = (NUM_TRADERS > 1) ? $clog2(NUM_TRADERS) : 1;
  localparam int SW  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int PD  = NUM_TRADERS * NUM_SYMBOLS;
  localparam int PW  = (PD > 1) ? $clog2(PD) : 1;
  localparam int SD  = NUM_TRADERS * RATE_DEPTH;
  localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
  localparam int HW  = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
  localparam int CW  = $clog2(RATE_DEPTH + 1);
  localparam int LW  = (CW > 5) ? CW : 5;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_RATE   = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]    st_r, st_nxt;
  logic [PW-1:0] clr_idx_r;

  logic [30:0] max_sym_r, max_net_r;
  logic [31:0] window_ms_r;
  logic [4:0]  max_ord_r;
  logic [51:0] window_r;

  logic [NUM_TRADERS-1:0] kill_r;
  logic                   gkill_r;
  logic [31:0]            checked_r, rejected_r;

  prc_pkg::job_t job_r;
  logic [TW-1:0] t_r;
  logic [SW-1:0] s_r;
  logic [HW-1:0] head_r;
  logic [CW-1:0] cnt_r;

  logic [2:0]         vd_r;
  logic signed [31:0] spos_r, snet_r;
  logic               killed_r;

  logic               out_valid_r;
  logic [2:0]         out_vd_r;
  logic signed [31:0] out_spos_r, out_snet_r;
  logic               out_killed_r;
  logic [31:0]        out_chk_r, out_rej_r;

  logic signed [31:0] pos_mem [PD];
  logic signed [31:0] net_mem [NUM_TRADERS];
  logic [HW-1:0]      head_mem [NUM_TRADERS];
  logic [CW-1:0]      cnt_mem [NUM_TRADERS];
  logic [63:0]        stamp_mem [SD];

  logic signed [31:0] pos_q, net_q;
  logic [HW-1:0]      head_q;
  logic [CW-1:0]      cnt_q;
  logic [63:0]        stamp_q;

  logic [TW-1:0] tmap [16];
  logic [SW-1:0] smap [16];

  for (genvar g = 0; g < 16; g++) begin : g_map
    assign tmap[g] = TW'(g % NUM_TRADERS);
    assign smap[g] = SW'(g % NUM_SYMBOLS);
  end

  logic [TW-1:0] tq;
  logic [SW-1:0] sq;
  logic [PW-1:0] pos_raddr, pos_cur_addr;

  assign tq           = tmap[q_job.trader];
  assign sq           = smap[q_job.symbol];
  assign pos_raddr    = PW'(32'(tq) * NUM_SYMBOLS + 32'(sq));
  assign pos_cur_addr = PW'(32'(t_r) * NUM_SYMBOLS + 32'(s_r));

  logic out_free;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign q_pop     = (st_r == ST_IDLE) && !q_empty;
  assign init_done = (st_r != ST_CLEAR);

  // projected and saturated positions
  logic signed [33:0] pos_sum, net_sum, delta_x;
  logic [33:0]        pos_mag, net_mag;
  logic signed [31:0] pos_sat, net_sat;
  logic               pos_bad, net_bad, killed_now;

  assign delta_x = 34'(job_r.delta);
  assign pos_sum = 34'(pos_q) + delta_x;
  assign net_sum = 34'(net_q) + delta_x;
  assign pos_mag = pos_sum[33] ? 34'(-pos_sum) : 34'(pos_sum);
  assign net_mag = net_sum[33] ? 34'(-net_sum) : 34'(net_sum);
  assign pos_bad = pos_mag > {3'b000, max_sym_r};
  assign net_bad = net_mag > {3'b000, max_net_r};
  assign killed_now = gkill_r || kill_r[t_r];

  always_comb begin
    if (pos_sum[33:31] == 3'b000 || pos_sum[33:31] == 3'b111) begin
      pos_sat = pos_sum[31:0];
    end else begin
      pos_sat = pos_sum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    if (net_sum[33:31] == 3'b000 || net_sum[33:31] == 3'b111) begin
      net_sat = net_sum[31:0];
    end else begin
      net_sat = net_sum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  // check verdict before the rate stage
  logic [2:0] rd_vd;
  logic       go_rate;

  always_comb begin
    go_rate = 1'b0;
    priority if (killed_now) begin
      rd_vd = prc_pkg::VERDICT_KILL;
    end else if (job_r.pre_verdict != prc_pkg::VERDICT_ACCEPT) begin
      rd_vd = job_r.pre_verdict;
    end else if (pos_bad || net_bad) begin
      rd_vd = prc_pkg::VERDICT_POSITION;
    end else begin
      rd_vd   = prc_pkg::VERDICT_ACCEPT;
      go_rate = 1'b1;
    end
  end

  logic is_check;
  assign is_check = (job_r.cmd == prc_pkg::CMD_CHECK);

  // ring window logic
  logic [63:0]   age;
  logic          expire, over_limit;
  logic [LW-1:0] limit;
  logic [HW-1:0] head_inc;
  logic [CW:0]   slot_sum;
  logic [HW-1:0] slot;

  assign age    = job_r.now - stamp_q;
  assign expire = (cnt_r != '0) && (age > {12'd0, window_r});
  assign limit  = (LW'(max_ord_r) < LW'(RATE_DEPTH)) ? LW'(max_ord_r) : LW'(RATE_DEPTH);
  assign over_limit = LW'(cnt_r) >= limit;
  assign head_inc = (32'(head_r) == RATE_DEPTH - 1) ? '0 : head_r + 1'b1;
  assign slot_sum = (CW + 1)'(head_r) + (CW + 1)'(cnt_r);
  assign slot = (32'(slot_sum) >= RATE_DEPTH) ? HW'(32'(slot_sum) - RATE_DEPTH)
                                               : HW'(slot_sum);

  // memory port control
  logic               pos_we, net_we, meta_we, stamp_we, stamp_re;
  logic [PW-1:0]      pos_waddr;
  logic [TW-1:0]      net_waddr;
  logic signed [31:0] pos_wdata, net_wdata;
  logic [HW-1:0]      head_wdata;
  logic [CW-1:0]      cnt_wdata;
  logic [SAW-1:0]     stamp_waddr, stamp_raddr;
  logic               clr_net;

  assign clr_net = 32'(clr_idx_r) < NUM_TRADERS;

  always_comb begin
    pos_we      = 1'b0;
    net_we      = 1'b0;
    meta_we     = 1'b0;
    stamp_we    = 1'b0;
    stamp_re    = 1'b0;
    pos_waddr   = pos_cur_addr;
    net_waddr   = t_r;
    pos_wdata   = pos_sat;
    net_wdata   = net_sat;
    head_wdata  = head_r;
    cnt_wdata   = cnt_r;
    stamp_waddr = SAW'(32'(t_r) * RATE_DEPTH + 32'(slot));
    stamp_raddr = SAW'(32'(t_r) * RATE_DEPTH + 32'(head_inc));
    unique case (st_r)
      ST_CLEAR: begin
        pos_we     = 1'b1;
        net_we     = clr_net;
        meta_we    = clr_net;
        pos_waddr  = clr_idx_r;
        net_waddr  = clr_idx_r[TW-1:0];
        pos_wdata  = '0;
        net_wdata  = '0;
        head_wdata = '0;
        cnt_wdata  = '0;
      end
      ST_READ: begin
        pos_we      = (job_r.cmd == prc_pkg::CMD_FILL);
        net_we      = (job_r.cmd == prc_pkg::CMD_FILL);
        stamp_re    = is_check && go_rate;
        stamp_raddr = SAW'(32'(t_r) * RATE_DEPTH + 32'(head_q));
      end
      ST_RATE: begin
        stamp_re  = expire;
        meta_we   = !expire;
        stamp_we  = !expire && !over_limit;
        cnt_wdata = over_limit ? cnt_r : cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (q_pop) begin
      pos_q <= pos_mem[pos_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (net_we) begin
      net_mem[net_waddr] <= net_wdata;
    end
    if (q_pop) begin
      net_q <= net_mem[tq];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      head_mem[st_r == ST_CLEAR ? clr_idx_r[TW-1:0] : t_r] <= head_wdata;
      cnt_mem[st_r == ST_CLEAR ? clr_idx_r[TW-1:0] : t_r]  <= cnt_wdata;
    end
    if (q_pop) begin
      head_q <= head_mem[tq];
      cnt_q  <= cnt_mem[tq];
    end
  end

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= job_r.now;
    end
    if (stamp_re) begin
      stamp_q <= stamp_mem[stamp_raddr];
    end
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR:  st_nxt = (32'(clr_idx_r) == PD - 1) ? ST_IDLE : ST_CLEAR;
      ST_IDLE:   st_nxt = q_empty ? ST_IDLE : ST_READ;
      ST_READ:   st_nxt = (is_check && go_rate) ? ST_RATE : ST_RESULT;
      ST_RATE:   st_nxt = expire ? ST_RATE : ST_RESULT;
      ST_RESULT: st_nxt = out_free ? ST_IDLE : ST_RESULT;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_idx_r   <= '0;
      max_sym_r   <= prc_pkg::RST_MAX_SYMBOL;
      max_net_r   <= prc_pkg::RST_MAX_NET;
      window_ms_r <= prc_pkg::RST_WINDOW_MS;
      max_ord_r   <= prc_pkg::RST_MAX_ORDERS;
      kill_r      <= '0;
      gkill_r     <= 1'b0;
      checked_r   <= '0;
      rejected_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          prc_pkg::CFG_MAX_SYMBOL: max_sym_r   <= cfg_ch.data[30:0];
          prc_pkg::CFG_MAX_NET:    max_net_r   <= cfg_ch.data[30:0];
          prc_pkg::CFG_WINDOW_MS:  window_ms_r <= cfg_ch.data;
          prc_pkg::CFG_MAX_ORDERS: max_ord_r   <= cfg_ch.data[4:0];
          default: begin
          end
        endcase
      end
      if (st_r == ST_READ) begin
        unique case (job_r.cmd)
          prc_pkg::CMD_CHECK: begin
            checked_r <= checked_r + 32'd1;
            if (!go_rate) begin
              rejected_r <= rejected_r + 32'd1;
            end
          end
          prc_pkg::CMD_KILL_ONE:   kill_r[t_r] <= 1'b1;
          prc_pkg::CMD_UNKILL_ONE: kill_r[t_r] <= 1'b0;
          prc_pkg::CMD_HALT_ALL:   gkill_r <= 1'b1;
          prc_pkg::CMD_RESUME_ALL: begin
            gkill_r <= 1'b0;
            kill_r  <= '0;
          end
          default: begin
          end
        endcase
      end
      if (st_r == ST_RATE && !expire && over_limit) begin
        rejected_r <= rejected_r + 32'd1;
      end
      if (st_r == ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    window_r <= window_ms_r * prc_pkg::NS_PER_MS;
    if (q_pop) begin
      job_r <= q_job;
      t_r   <= tq;
      s_r   <= sq;
    end
    if (st_r == ST_READ) begin
      head_r <= head_q;
      cnt_r  <= cnt_q;
      spos_r <= (job_r.cmd == prc_pkg::CMD_FILL) ? pos_sat : pos_q;
      snet_r <= (job_r.cmd == prc_pkg::CMD_FILL) ? net_sat : net_q;
      vd_r   <= is_check ? rd_vd : prc_pkg::VERDICT_ACCEPT;
      unique case (job_r.cmd)
        prc_pkg::CMD_KILL_ONE:   killed_r <= 1'b1;
        prc_pkg::CMD_UNKILL_ONE: killed_r <= gkill_r;
        prc_pkg::CMD_HALT_ALL:   killed_r <= 1'b1;
        prc_pkg::CMD_RESUME_ALL: killed_r <= 1'b0;
        default:                 killed_r <= killed_now;
      endcase
    end
    if (st_r == ST_RATE) begin
      if (expire) begin
        head_r <= head_inc;
        cnt_r  <= cnt_r - 1'b1;
      end else if (over_limit) begin
        vd_r <= prc_pkg::VERDICT_RATE;
      end
    end
    if (st_r == ST_RESULT && out_free) begin
      out_vd_r     <= vd_r;
      out_spos_r   <= spos_r;
      out_snet_r   <= snet_r;
      out_killed_r <= killed_r;
      out_chk_r    <= checked_r;
      out_rej_r    <= rejected_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.verdict         = out_vd_r;
  assign out_ch.symbol_position = out_spos_r;
  assign out_ch.net_total       = out_snet_r;
  assign out_ch.trader_killed   = out_killed_r;
  assign out_ch.orders_checked  = out_chk_r;
  assign out_ch.orders_rejected = out_rej_r;

  `PRC_ASSERT_IMPLY(a_rate_only_checks, clk, rst_n, st_r == ST_RATE, job_r.cmd == prc_pkg::CMD_CHECK)
  `PRC_ASSERT_IMPLY(a_ring_bound, clk, rst_n, st_r == ST_RATE, 32'(cnt_r) <= RATE_DEPTH)
  `PRC_ASSERT_IMPLY(a_no_pop_in_clear, clk, rst_n, st_r == ST_CLEAR, !q_pop)
  `PRC_ASSERT_NEXT(a_check_counted, clk, rst_n, st_r == ST_READ && is_check, checked_r == $past(checked_r) + 32'd1)

endmodule

`default_nettype wire

### sim/pretrade_risk_checker_core_tb.sv
// testbench of pretrade_risk_checker_core: directed table, then random requests per limit setting
// every result is checked per field against an in-bench risk model; typed rows set the verdict
// depends on prc_pkg, prc_if and the pretrade_risk_checker_core rtl
`default_nettype none

module pretrade_risk_checker_core_tb;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam int         N_TRADERS   = 16;
  localparam int         N_SYMBOLS   = 16;
  localparam int         RING_DEPTH  = 16;
  localparam int         DRAIN_WAIT  = 60;
  localparam int         STALL_LIMIT = 6000;
  localparam int         RAND_PER_SETTING = 320;
  localparam int         N_SETTINGS  = 6;

  typedef struct {
    logic [2:0]         cmd;
    logic [3:0]         trader;
    logic [3:0]         symbol;
    logic               side;
    logic signed [31:0] qty;
    logic signed [31:0] price;
    logic               is_limit;
    logic [63:0]        ts;
  } order_t;

  typedef struct {
    logic [2:0]         verdict;
    logic signed [31:0] sym_pos;
    logic signed [31:0] net_pos;
    logic               killed;
    logic [31:0]        checked;
    logic [31:0]        rejected;
  } verdict_t;

  typedef struct {
    order_t     req;
    logic       typed;
    logic [2:0] verdict;
  } row_t;

  logic clk;
  logic rst_n;

  prc_req_if req();
  prc_res_if res();
  prc_cfg_if cfg();

  pretrade_risk_checker_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req),
    .out_ch (res),
    .cfg_ch (cfg)
  );

  // model state
  logic [30:0]        lim_sym;
  logic [30:0]        lim_net;
  logic [31:0]        win_ms;
  logic [4:0]         max_orders;
  logic signed [31:0] pos_tbl [N_TRADERS][N_SYMBOLS];
  logic signed [31:0] net_tbl [N_TRADERS];
  logic               kill_one [N_TRADERS];
  logic               kill_global;
  logic [63:0]        stamps [N_TRADERS][RING_DEPTH];
  logic [3:0]         head [N_TRADERS];
  int                 fill_cnt [N_TRADERS];
  logic [31:0]        n_checked;
  logic [31:0]        n_rejected;

  verdict_t expected_q[$];
  int       mismatches;
  int       n_sent;
  int       n_results;
  int       verdict_hist [8];
  int       idle_cycles;
  logic     steady;
  logic [63:0] now_ns;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [2:0] rate_take(input int t, input logic [63:0] stamp);
    logic [63:0] window;
    int          cap;
    logic [3:0]  slot;
    window = 64'(win_ms) * 64'd1000000;
    cap = max_orders < RING_DEPTH ? int'(max_orders) : RING_DEPTH;
    while (fill_cnt[t] > 0 && (stamp - stamps[t][head[t]]) > window) begin
      head[t] = head[t] + 4'd1;
      fill_cnt[t]--;
    end
    if (fill_cnt[t] >= cap) return prc_pkg::VERDICT_RATE;
    slot = head[t] + 4'(fill_cnt[t]);
    stamps[t][slot] = stamp;
    fill_cnt[t]++;
    return prc_pkg::VERDICT_ACCEPT;
  endfunction

  function automatic verdict_t risk_predict(input order_t r);
    verdict_t o;
    longint   d;
    int       t;
    int       s;
    t = r.trader;
    s = r.symbol;
    d = r.side ? -longint'(r.qty) : longint'(r.qty);
    o.verdict = prc_pkg::VERDICT_ACCEPT;
    case (r.cmd)
      prc_pkg::CMD_CHECK: begin
        n_checked++;
        if (kill_global || kill_one[t]) o.verdict = prc_pkg::VERDICT_KILL;
        else if (r.is_limit && r.price <= 0) o.verdict = prc_pkg::VERDICT_BAD_PRICE;
        else if (r.qty <= 0) o.verdict = prc_pkg::VERDICT_BAD_QTY;
        else if (mag(longint'(pos_tbl[t][s]) + d) > longint'(lim_sym) ||
                 mag(longint'(net_tbl[t]) + d) > longint'(lim_net))
          o.verdict = prc_pkg::VERDICT_POSITION;
        else o.verdict = rate_take(t, r.ts);
        if (o.verdict != prc_pkg::VERDICT_ACCEPT) n_rejected++;
      end
      prc_pkg::CMD_FILL: begin
        pos_tbl[t][s] = sat32(longint'(pos_tbl[t][s]) + d);
        net_tbl[t] = sat32(longint'(net_tbl[t]) + d);
      end
      prc_pkg::CMD_KILL_ONE: kill_one[t] = 1'b1;
      prc_pkg::CMD_UNKILL_ONE: kill_one[t] = 1'b0;
      prc_pkg::CMD_HALT_ALL: kill_global = 1'b1;
      prc_pkg::CMD_RESUME_ALL: begin
        kill_global = 1'b0;
        foreach (kill_one[i]) kill_one[i] = 1'b0;
      end
      default: ;
    endcase
    o.sym_pos  = pos_tbl[t][s];
    o.net_pos  = net_tbl[t];
    o.killed   = kill_global | kill_one[t];
    o.checked  = n_checked;
    o.rejected = n_rejected;
    return o;
  endfunction

  task automatic model_reset();
    lim_sym = prc_pkg::RST_MAX_SYMBOL;
    lim_net = prc_pkg::RST_MAX_NET;
    win_ms = prc_pkg::RST_WINDOW_MS;
    max_orders = prc_pkg::RST_MAX_ORDERS;
    foreach (pos_tbl[i, j]) pos_tbl[i][j] = '0;
    foreach (net_tbl[i]) begin
      net_tbl[i] = '0;
      kill_one[i] = 1'b0;
      head[i] = '0;
      fill_cnt[i] = 0;
    end
    kill_global = 1'b0;
    n_checked = '0;
    n_rejected = '0;
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst_n || steady || $urandom_range(0, 99) >= 27) res.ready <= 1'b1;
    else res.ready <= 1'b0;
  end

  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && res.valid && res.ready) begin
      n_results++;
      verdict_hist[res.verdict]++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, verdict %0d", res.verdict);
      end else begin
        e = expected_q[0];
        expected_q.delete(0);
        if (res.verdict !== e.verdict || res.symbol_position !== e.sym_pos ||
            res.net_total !== e.net_pos || res.trader_killed !== e.killed ||
            res.orders_checked !== e.checked || res.orders_rejected !== e.rejected) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp v=%0d pos=%0d net=%0d k=%0b chk=%0d rej=%0d",
                      " | got v=%0d pos=%0d net=%0d k=%0b chk=%0d rej=%0d"},
                     e.verdict, e.sym_pos, e.net_pos, e.killed, e.checked, e.rejected,
                     res.verdict, res.symbol_position, res.net_total,
                     res.trader_killed, res.orders_checked, res.orders_rejected);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_order(input order_t r, input logic typed, input logic [2:0] v);
    verdict_t e;
    if (!steady && $urandom_range(0, 99) < 27) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 27);
    end
    req.valid        <= 1'b1;
    req.command      <= r.cmd;
    req.trader_index <= r.trader;
    req.symbol_index <= r.symbol;
    req.side         <= r.side;
    req.quantity     <= r.qty;
    req.limit_price  <= r.price;
    req.is_limit     <= r.is_limit;
    req.timestamp_ns <= r.ts;
    do @(posedge clk); while (!req.ready);
    e = risk_predict(r);
    if (typed) e.verdict = v;
    expected_q.insert(expected_q.size(), e);
    n_sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      prc_pkg::CFG_MAX_SYMBOL: lim_sym = val[30:0];
      prc_pkg::CFG_MAX_NET:    lim_net = val[30:0];
      prc_pkg::CFG_WINDOW_MS:  win_ms = val;
      prc_pkg::CFG_MAX_ORDERS: max_orders = val[4:0];
      default: ;
    endcase
  endtask

  function automatic order_t mk(input logic [2:0] c, input int t, input int s,
                                input logic sd, input logic signed [31:0] q,
                                input logic signed [31:0] p, input logic lim);
    order_t r;
    r.cmd = c;
    r.trader = 4'(t);
    r.symbol = 4'(s);
    r.side = sd;
    r.qty = q;
    r.price = p;
    r.is_limit = lim;
    r.ts = now_ns;
    return r;
  endfunction

  function automatic order_t random_order();
    order_t r;
    int     pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 199) == 0) now_ns = {$urandom, $urandom};
    else if ($urandom_range(0, 49) == 0) now_ns = now_ns - 64'($urandom_range(0, 5000000));
    else now_ns = now_ns + 64'($urandom_range(0, 400000));
    r = mk(prc_pkg::CMD_CHECK, $urandom_range(0, 3), $urandom_range(0, 3),
           1'($urandom_range(0, 1)), 32'($urandom_range(1, 400)),
           32'($urandom_range(1, 100000)), 1'($urandom_range(0, 1)));
    if (pick < 55) begin
      if ($urandom_range(0, 9) == 0) r.qty = -32'sd1 * 32'($urandom_range(0, 50));
      if ($urandom_range(0, 9) == 0) r.price = -32'sd1 * 32'($urandom_range(0, 50));
    end else if (pick < 72) begin
      r.cmd = prc_pkg::CMD_FILL;
      r.qty = 32'($urandom_range(0, 600)) - 32'sd300;
    end else if (pick < 75) begin
      r.cmd = prc_pkg::CMD_FILL;
      r.qty = $urandom;
    end else if (pick < 79) r.cmd = prc_pkg::CMD_KILL_ONE;
    else if (pick < 85) r.cmd = prc_pkg::CMD_UNKILL_ONE;
    else if (pick < 87) r.cmd = prc_pkg::CMD_HALT_ALL;
    else if (pick < 89) r.cmd = prc_pkg::CMD_RESUME_ALL;
    else begin
      r.cmd = 3'($urandom_range(0, 7));
      r.trader = 4'($urandom);
      r.symbol = 4'($urandom);
      r.qty = $urandom;
      r.price = $urandom;
    end
    r.ts = now_ns;
    return r;
  endfunction

  row_t        rows[$];
  logic [31:0] settings [N_SETTINGS][4];

  task automatic add_row(input order_t r, input logic typed, input logic [2:0] v);
    rows.insert(rows.size(), row_t'{r, typed, v});
  endtask

  initial begin
    rst_n = 1'b0;
    req.valid = 1'b0;
    req.command = prc_pkg::CMD_CHECK;
    req.trader_index = '0;
    req.symbol_index = '0;
    req.side = 1'b0;
    req.quantity = '0;
    req.limit_price = '0;
    req.is_limit = 1'b0;
    req.timestamp_ns = '0;
    res.ready = 1'b1;
    cfg.valid = 1'b0;
    cfg.index = prc_pkg::CFG_MAX_SYMBOL;
    cfg.data = '0;
    mismatches = 0;
    n_sent = 0;
    n_results = 0;
    idle_cycles = 0;
    steady = 1'b0;
    foreach (verdict_hist[i]) verdict_hist[i] = 0;
    now_ns = 64'h0000_0000_0001_0000;
    model_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    add_row(mk(prc_pkg::CMD_CHECK, 0, 0, 1'b0, 10, 100, 1'b1), 1'b1,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(prc_pkg::CMD_CHECK, 0, 0, 1'b0, 0, 100, 1'b1), 1'b1,
            prc_pkg::VERDICT_BAD_QTY);
    add_row(mk(prc_pkg::CMD_CHECK, 0, 0, 1'b0, 5, 0, 1'b1), 1'b1,
            prc_pkg::VERDICT_BAD_PRICE);
    add_row(mk(prc_pkg::CMD_CHECK, 0, 0, 1'b1, 5, 32'sh80000000, 1'b1), 1'b1,
            prc_pkg::VERDICT_BAD_PRICE);
    add_row(mk(prc_pkg::CMD_CHECK, 0, 1, 1'b1, 5, -5, 1'b0), 1'b1,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(prc_pkg::CMD_CHECK, 0, 0, 1'b0, 32'sh80000000, 9, 1'b1), 1'b1,
            prc_pkg::VERDICT_BAD_QTY);
    add_row(mk(prc_pkg::CMD_CHECK, 0, 2, 1'b0, 1001, 9, 1'b1), 1'b1,
            prc_pkg::VERDICT_POSITION);
    add_row(mk(prc_pkg::CMD_CHECK, 0, 2, 1'b1, 32'sh7fffffff, 9, 1'b0), 1'b1,
            prc_pkg::VERDICT_POSITION);
    add_row(mk(prc_pkg::CMD_FILL, 1, 2, 1'b0, 32'sh7fffffff, 0, 1'b0), 1'b0,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(prc_pkg::CMD_FILL, 1, 2, 1'b0, 32'sh7fffffff, 0, 1'b0), 1'b0,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(prc_pkg::CMD_FILL, 1, 3, 1'b1, 32'sh80000000, 0, 1'b0), 1'b0,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(prc_pkg::CMD_FILL, 1, 2, 1'b1, 32'sh7fffffff, 0, 1'b0), 1'b0,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(prc_pkg::CMD_FILL, 1, 2, 1'b1, 32'sh7fffffff, 0, 1'b0), 1'b0,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(prc_pkg::CMD_FILL, 1, 2, 1'b1, 32'sh7fffffff, 0, 1'b0), 1'b0,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(prc_pkg::CMD_KILL_ONE, 3, 0, 1'b0, 0, 0, 1'b0), 1'b0,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(prc_pkg::CMD_CHECK, 3, 0, 1'b0, 1, 1, 1'b1), 1'b1,
            prc_pkg::VERDICT_KILL);
    add_row(mk(prc_pkg::CMD_UNKILL_ONE, 3, 0, 1'b0, 0, 0, 1'b0), 1'b0,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(prc_pkg::CMD_HALT_ALL, 5, 0, 1'b0, 0, 0, 1'b0), 1'b0,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(prc_pkg::CMD_CHECK, 5, 7, 1'b0, 1, 1, 1'b1), 1'b1,
            prc_pkg::VERDICT_KILL);
    add_row(mk(prc_pkg::CMD_KILL_ONE, 6, 0, 1'b0, 0, 0, 1'b0), 1'b0,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(prc_pkg::CMD_RESUME_ALL, 0, 0, 1'b0, 0, 0, 1'b0), 1'b0,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(prc_pkg::CMD_CHECK, 6, 0, 1'b0, 1, 1, 1'b1), 1'b1,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(CMD_SPARE_A, 15, 15, 1'b1, -1, -1, 1'b1), 1'b1,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(CMD_SPARE_B, 1, 2, 1'b1, -1, -1, 1'b1), 1'b1,
            prc_pkg::VERDICT_ACCEPT);
    add_row(mk(prc_pkg::CMD_CHECK, 15, 15, 1'b1, 1000, 32'sh7fffffff, 1'b1), 1'b1,
            prc_pkg::VERDICT_ACCEPT);
    foreach (rows[i]) send_order(rows[i].req, rows[i].typed, rows[i].verdict);
    drain();

    settings[0] = '{32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'd16};
    settings[1] = '{32'd0, 32'd0, 32'd0, 32'd0};
    settings[2] = '{32'd500, 32'd2000, 32'd1, 32'd3};
    settings[3] = '{32'd3000, 32'd1500, 32'd2, 32'd1};
    settings[4] = '{32'd800, 32'd800, 32'd0, 32'd8};
    settings[5] = '{32'd2000, 32'd5000, 32'd1, 32'd16};
    for (int k = 0; k < N_SETTINGS; k++) begin
      write_reg(prc_pkg::CFG_MAX_SYMBOL, settings[k][0]);
      write_reg(prc_pkg::CFG_MAX_NET, settings[k][1]);
      write_reg(prc_pkg::CFG_WINDOW_MS, settings[k][2]);
      write_reg(prc_pkg::CFG_MAX_ORDERS, settings[k][3]);
      // run one setting across the 64-bit timestamp wrap
      if (k == 2) now_ns = 64'hffff_ffff_fff0_0000;
      for (int n = 0; n < RAND_PER_SETTING; n++) begin
        steady = (k == 3 && n >= 60 && n < 260);
        if (n == RAND_PER_SETTING / 2) begin
          req.valid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
        send_order(random_order(), 1'b0, prc_pkg::VERDICT_ACCEPT);
      end
      steady = 1'b0;
      drain();
    end

    $display("%0d requests, %0d results over %0d limit settings", n_sent, n_results,
             N_SETTINGS + 1);
    $display("verdicts: accept %0d kill %0d price %0d qty %0d position %0d rate %0d",
             verdict_hist[0], verdict_hist[1], verdict_hist[2], verdict_hist[3],
             verdict_hist[4], verdict_hist[5]);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
